>>> src/deq_pkg.sv
// Shared types for the double-ended queue: command and status codes.
// No dependencies; compiled first.
package deq_pkg;

    // Command codes carried on the command channel
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_COPY_FRONT = 3'd4,
        CMD_COPY_BACK  = 3'd5,
        CMD_CLEAR      = 3'd6,
        CMD_QUERY      = 3'd7
    } t_cmd;

    // Status codes returned with every response
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

>>> src/deq_if.sv
// Valid/ready channel interfaces for the double-ended queue.
// Depends on deq_pkg for the command and status types.
interface deq_cmd_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    deq_pkg::t_cmd         cmd;
    logic [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_rsp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_WIDTH  = 5
);
    logic                  valid;
    logic                  ready;
    deq_pkg::t_status      status;
    logic [CNT_WIDTH-1:0]  entry_count;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;

    modport source (output valid, output status, output entry_count,
                    output front_value, output back_value, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input front_value, input back_value, output ready);
endinterface

>>> src/deq_ram.sv
// Entry storage for the double-ended queue: one write port, one read port,
// registered read data. No package dependencies.
module deq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_WIDTH-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [ADDR_WIDTH-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/double_ended_queue.sv
// Channel   Dir  Handshake    Payload
// i_cmd     in   valid/ready  cmd, push_value
// o_rsp     out  valid/ready  status, entry_count, front_value, back_value
//
// Pushes, copies, clear, query, errors and pops that leave at most one entry
// load the response register straight from the decode; a pop that leaves two
// or more entries passes through the read state to fetch the new end value.
// Reset is synchronous and active low; the queue comes up empty, no clearing
// pass. A new command is taken while a response waits if that response
// transfers in the same cycle; a stalled response holds the command channel.
// Top level of the double-ended queue; depends on deq_pkg, deq_if, deq_ram.
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    deq_cmd_if.sink       i_cmd,
    deq_rsp_if.source     o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_front_idx, n_front_idx;
    logic [AW-1:0]         r_back_idx, n_back_idx;
    logic [DATA_WIDTH-1:0] r_front_val, n_front_val;
    logic [DATA_WIDTH-1:0] r_back_val, n_back_val;
    logic                  r_rd_front, n_rd_front;
    logic                  r_out_valid, n_out_valid;
    deq_pkg::t_status      r_out_status, n_out_status;
    logic [CW-1:0]         r_out_count, n_out_count;
    logic [DATA_WIDTH-1:0] r_out_front, n_out_front;
    logic [DATA_WIDTH-1:0] r_out_back, n_out_back;

    logic                  cmd_acc;
    logic                  is_empty;
    logic                  is_full;
    logic                  rd_req;
    deq_pkg::t_status      res_status;
    logic [AW-1:0]         front_inc, front_dec, back_inc, back_dec;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Handshakes
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    // Circular neighbors of the end slots
    assign front_inc = (r_front_idx == LAST_IDX) ? '0 : r_front_idx + AW'(1);
    assign front_dec = (r_front_idx == '0) ? LAST_IDX : r_front_idx - AW'(1);
    assign back_inc  = (r_back_idx == LAST_IDX) ? '0 : r_back_idx + AW'(1);
    assign back_dec  = (r_back_idx == '0) ? LAST_IDX : r_back_idx - AW'(1);

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FULL_CNT);

    // Decode the command, update the end slots and stage the response
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_front_idx  = r_front_idx;
        n_back_idx   = r_back_idx;
        n_front_val  = r_front_val;
        n_back_val   = r_back_val;
        n_rd_front   = r_rd_front;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_front  = r_out_front;
        n_out_back   = r_out_back;
        res_status   = deq_pkg::ST_OK;
        rd_req       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = front_dec;
        mem_wdata    = i_cmd.push_value;
        mem_raddr    = front_inc;

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    case (i_cmd.cmd)
                        deq_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                res_status = deq_pkg::ST_FULL;
                            end else begin
                                mem_we      = 1'b1;
                                mem_waddr   = front_dec;
                                n_front_idx = front_dec;
                                n_front_val = i_cmd.push_value;
                                if (is_empty) begin
                                    n_back_idx = front_dec;
                                    n_back_val = i_cmd.push_value;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_PUSH_BACK: begin
                            if (is_full) begin
                                res_status = deq_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = is_empty ? r_front_idx : back_inc;
                                n_back_idx = mem_waddr;
                                n_back_val = i_cmd.push_value;
                                if (is_empty) begin
                                    n_front_val = i_cmd.push_value;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_POP_FRONT: begin
                            if (is_empty) begin
                                res_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_front_idx = front_inc;
                                n_count     = r_count - CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_front_val = r_front_val;
                                end else if (r_count == CW'(2)) begin
                                    n_front_val = r_back_val;
                                end else begin
                                    rd_req     = 1'b1;
                                    mem_raddr  = front_inc;
                                    n_rd_front = 1'b1;
                                end
                            end
                        end
                        deq_pkg::CMD_POP_BACK: begin
                            if (is_empty) begin
                                res_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_back_idx = back_dec;
                                n_count    = r_count - CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_back_val = r_back_val;
                                end else if (r_count == CW'(2)) begin
                                    n_back_val = r_front_val;
                                end else begin
                                    rd_req     = 1'b1;
                                    mem_raddr  = back_dec;
                                    n_rd_front = 1'b0;
                                end
                            end
                        end
                        deq_pkg::CMD_COPY_FRONT: begin
                            if (is_empty) begin
                                res_status = deq_pkg::ST_EMPTY;
                            end else if (is_full) begin
                                res_status = deq_pkg::ST_FULL;
                            end else begin
                                mem_we      = 1'b1;
                                mem_waddr   = front_dec;
                                mem_wdata   = r_front_val;
                                n_front_idx = front_dec;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_COPY_BACK: begin
                            if (is_empty) begin
                                res_status = deq_pkg::ST_EMPTY;
                            end else if (is_full) begin
                                res_status = deq_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = back_inc;
                                mem_wdata  = r_back_val;
                                n_back_idx = back_inc;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_CLEAR: begin
                            if (is_empty) begin
                                res_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_count     = '0;
                                n_front_idx = '0;
                            end
                        end
                        deq_pkg::CMD_QUERY: begin
                            res_status = deq_pkg::ST_OK;
                        end
                        default: begin
                            res_status = deq_pkg::ST_OK;
                        end
                    endcase

                    // Either wait for the memory or load the response now
                    if (rd_req) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = res_status;
                        n_out_count  = n_count;
                        n_out_front  = (n_count == '0) ? '0 : n_front_val;
                        n_out_back   = (n_count == '0) ? '0 : n_back_val;
                    end
                end
            end
            S_READ: begin
                // Take the fetched end value and release the response
                if (r_rd_front) begin
                    n_front_val = mem_rdata;
                end else begin
                    n_back_val = mem_rdata;
                end
                n_out_valid  = 1'b1;
                n_out_status = deq_pkg::ST_OK;
                n_out_count  = r_count;
                n_out_front  = r_rd_front ? mem_rdata : r_front_val;
                n_out_back   = r_rd_front ? r_back_val : mem_rdata;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_front_idx <= '0;
            r_back_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_front_idx <= n_front_idx;
            r_back_idx  <= n_back_idx;
            r_out_valid <= n_out_valid;
        end
        r_front_val  <= n_front_val;
        r_back_val   <= n_back_val;
        r_rd_front   <= n_rd_front;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_front  <= n_out_front;
        r_out_back   <= n_out_back;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.back_value  = r_out_back;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds depth");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && rd_req) |=> (r_state == S_READ) && !r_out_valid)
        else $error("pop with memory fetch did not enter read state");

    a_read_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !i_cmd.ready)
        else $error("command taken during memory fetch");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.entry_count == '0) |->
            (o_rsp.front_value == '0) && (o_rsp.back_value == '0))
        else $error("empty response carries nonzero values");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == deq_pkg::ST_FULL) |->
            (o_rsp.entry_count == FULL_CNT))
        else $error("full error reported below capacity");
`endif

endmodule

>>> test/double_ended_queue_test.sv
// Self-checking testbench for the double-ended queue: directed table, then random commands.
// Predicts each response in-house and checks it field by field against the DUT.
// Depends on deq_pkg, deq_if and double_ended_queue from the RTL tree.
module double_ended_queue_test;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int CNT_WIDTH    = 5;
    localparam int RANDOM_ITEMS = 800;
    localparam int TAIL_ITEMS   = 120;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PLAN_ROWS    = 22;

    typedef struct packed {
        deq_pkg::t_status      status;
        logic [CNT_WIDTH-1:0]  count;
        logic [DATA_WIDTH-1:0] front;
        logic [DATA_WIDTH-1:0] back;
    } t_deq_result;

    // One directed row: command, value, repeat count (value steps by one per repeat),
    // and an optional typed-in expected response
    typedef struct packed {
        deq_pkg::t_cmd         op;
        logic [DATA_WIDTH-1:0] value;
        logic [4:0]            reps;
        logic                  typed;
        t_deq_result           result;
    } t_plan_row;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    localparam t_plan_row DIRECTED_PLAN [PLAN_ROWS] = '{
        '{deq_pkg::CMD_QUERY,      32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_OK,    5'd0, 32'h0, 32'h0}},
        '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_EMPTY, 5'd0, 32'h0, 32'h0}},
        '{deq_pkg::CMD_POP_BACK,   32'hFFFF_FFFF, 5'd1,  1'b1,
          '{deq_pkg::ST_EMPTY, 5'd0, 32'h0, 32'h0}},
        '{deq_pkg::CMD_COPY_FRONT, 32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_EMPTY, 5'd0, 32'h0, 32'h0}},
        '{deq_pkg::CMD_COPY_BACK,  32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_EMPTY, 5'd0, 32'h0, 32'h0}},
        '{deq_pkg::CMD_CLEAR,      32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_EMPTY, 5'd0, 32'h0, 32'h0}},
        '{deq_pkg::CMD_PUSH_BACK,  32'hFFFF_FFFF, 5'd1,  1'b1,
          '{deq_pkg::ST_OK, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{deq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_OK, 5'd2, 32'h0000_0000, 32'hFFFF_FFFF}},
        '{deq_pkg::CMD_COPY_FRONT, 32'h0000_0000, 5'd1,  1'b0, '0},
        '{deq_pkg::CMD_COPY_BACK,  32'h0000_0000, 5'd1,  1'b0, '0},
        '{deq_pkg::CMD_PUSH_FRONT, 32'hA5A5_5A5A, 5'd1,  1'b0, '0},
        '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, '0},
        '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, '0},
        '{deq_pkg::CMD_CLEAR,      32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_OK, 5'd0, 32'h0, 32'h0}},
        '{deq_pkg::CMD_PUSH_BACK,  32'h0000_0100, 5'd16, 1'b0, '0},
        '{deq_pkg::CMD_PUSH_FRONT, 32'h1234_5678, 5'd1,  1'b1,
          '{deq_pkg::ST_FULL, 5'd16, 32'h0000_0100, 32'h0000_010F}},
        '{deq_pkg::CMD_PUSH_BACK,  32'h8765_4321, 5'd1,  1'b1,
          '{deq_pkg::ST_FULL, 5'd16, 32'h0000_0100, 32'h0000_010F}},
        '{deq_pkg::CMD_COPY_FRONT, 32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_FULL, 5'd16, 32'h0000_0100, 32'h0000_010F}},
        '{deq_pkg::CMD_COPY_BACK,  32'h0000_0000, 5'd1,  1'b1,
          '{deq_pkg::ST_FULL, 5'd16, 32'h0000_0100, 32'h0000_010F}},
        '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, '0},
        '{deq_pkg::CMD_COPY_BACK,  32'h0000_0000, 5'd1,  1'b0, '0},
        '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    deq_cmd_if #(.DATA_WIDTH(DATA_WIDTH)) cmd_ch ();
    deq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_WIDTH(CNT_WIDTH)) rsp_ch ();

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow deque state
    logic [DATA_WIDTH-1:0] shadow_slots [DEPTH];
    logic [3:0]            head_slot;
    logic [CNT_WIDTH-1:0]  live_count;

    t_deq_result pending_results [$];
    t_deq_result oldest_result;

    int unsigned cycle_count       = 0;
    int unsigned error_count       = 0;
    int unsigned commands_sent     = 0;
    int unsigned responses_checked = 0;
    int unsigned ok_seen           = 0;
    int unsigned empty_seen        = 0;
    int unsigned full_seen         = 0;
    int unsigned peak_count        = 0;
    int unsigned sender_idle_pct   = 15;
    int unsigned stall_left        = 0;
    bit          quiet_tail        = 1'b0;
    bit          long_hold_done    = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void insert_front(input logic [DATA_WIDTH-1:0] value);
        head_slot               = head_slot - 4'd1;
        shadow_slots[head_slot] = value;
        live_count              = live_count + 5'd1;
    endfunction

    function automatic void insert_back(input logic [DATA_WIDTH-1:0] value);
        logic [3:0] tail;
        tail               = head_slot + live_count[3:0];
        shadow_slots[tail] = value;
        live_count         = live_count + 5'd1;
    endfunction

    // Apply one command to the shadow deque and return the response it produces
    function automatic void apply_command(input deq_pkg::t_cmd op,
                                          input logic [DATA_WIDTH-1:0] value,
                                          output t_deq_result res);
        logic [3:0] back_idx;
        logic       empty;
        logic       full;
        empty      = (live_count == '0);
        full       = (live_count == CNT_WIDTH'(DEPTH));
        back_idx   = head_slot + live_count[3:0] - 4'd1;
        res.status = deq_pkg::ST_OK;
        case (op)
            deq_pkg::CMD_PUSH_FRONT: begin
                if (full) res.status = deq_pkg::ST_FULL;
                else      insert_front(value);
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (full) res.status = deq_pkg::ST_FULL;
                else      insert_back(value);
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (empty) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    head_slot  = head_slot + 4'd1;
                    live_count = live_count - 5'd1;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (empty) res.status = deq_pkg::ST_EMPTY;
                else       live_count = live_count - 5'd1;
            end
            deq_pkg::CMD_COPY_FRONT: begin
                if (empty)     res.status = deq_pkg::ST_EMPTY;
                else if (full) res.status = deq_pkg::ST_FULL;
                else           insert_front(shadow_slots[head_slot]);
            end
            deq_pkg::CMD_COPY_BACK: begin
                if (empty)     res.status = deq_pkg::ST_EMPTY;
                else if (full) res.status = deq_pkg::ST_FULL;
                else           insert_back(shadow_slots[back_idx]);
            end
            deq_pkg::CMD_CLEAR: begin
                if (empty) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    live_count = '0;
                    head_slot  = '0;
                end
            end
            default: ;
        endcase
        // An empty deque reports zero at both ends
        back_idx  = head_slot + live_count[3:0] - 4'd1;
        res.count = live_count;
        if (live_count != '0) begin
            res.front = shadow_slots[head_slot];
            res.back  = shadow_slots[back_idx];
        end else begin
            res.front = '0;
            res.back  = '0;
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_WIDTH-1:0] got,
                                   input logic [DATA_WIDTH-1:0] want);
        $display("mismatch: %s on response %0d: got %h, expected %h",
                 field, responses_checked, got, want);
        error_count++;
    endtask

    // Offer one command, wait for its transfer, record the expectation, maybe go idle.
    // Called at a falling edge and returns at a falling edge.
    task automatic offer(input deq_pkg::t_cmd op, input logic [DATA_WIDTH-1:0] value,
                         input logic typed, input t_deq_result typed_result);
        t_deq_result predicted;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= op;
        cmd_ch.push_value <= value;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        apply_command(op, value, predicted);
        pending_results.push_back(typed ? typed_result : predicted);
        commands_sent++;
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 99) < sender_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    // Weight commands so the deque drifts toward full, toward empty, or wanders
    function automatic deq_pkg::t_cmd pick_command(input t_mix mix);
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        int unsigned copy_pct;
        int unsigned clear_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_pct = 60; pop_pct = 20; copy_pct = 12; clear_pct = 1; end
            MIX_DRAIN: begin push_pct = 22; pop_pct = 62; copy_pct = 6;  clear_pct = 2; end
            default:   begin push_pct = 40; pop_pct = 40; copy_pct = 10; clear_pct = 3; end
        endcase
        if (roll < push_pct)
            return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
        if (roll < push_pct + pop_pct + copy_pct)
            return $urandom_range(0, 1) ? deq_pkg::CMD_COPY_BACK : deq_pkg::CMD_COPY_FRONT;
        if (roll < push_pct + pop_pct + copy_pct + clear_pct)
            return deq_pkg::CMD_CLEAR;
        return deq_pkg::CMD_QUERY;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    // Response side: random stall bursts, one long hold-off, none in the tail
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && responses_checked >= 300) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left   = $urandom_range(1, 8) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Check every response transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("response with nothing pending", rsp_ch.front_value, '0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (rsp_ch.status !== oldest_result.status)
                    report_mismatch("status", DATA_WIDTH'(rsp_ch.status),
                                    DATA_WIDTH'(oldest_result.status));
                if (rsp_ch.entry_count !== oldest_result.count)
                    report_mismatch("entry_count", DATA_WIDTH'(rsp_ch.entry_count),
                                    DATA_WIDTH'(oldest_result.count));
                if (rsp_ch.front_value !== oldest_result.front)
                    report_mismatch("front_value", rsp_ch.front_value, oldest_result.front);
                if (rsp_ch.back_value !== oldest_result.back)
                    report_mismatch("back_value", rsp_ch.back_value, oldest_result.back);
            end
            case (rsp_ch.status)
                deq_pkg::ST_OK:    ok_seen++;
                deq_pkg::ST_EMPTY: empty_seen++;
                deq_pkg::ST_FULL:  full_seen++;
                default: ;
            endcase
            if (rsp_ch.entry_count > peak_count) peak_count = 32'(rsp_ch.entry_count);
            responses_checked++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, pending_results.size());
            $display("double_ended_queue_test NOT OK");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        t_mix mix;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = deq_pkg::CMD_QUERY;
        cmd_ch.push_value = '0;
        i_rst_n           = 1'b0;
        head_slot         = '0;
        live_count        = '0;
        mix               = MIX_EVEN;

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (DIRECTED_PLAN[row]) begin
            for (int rep = 0; rep < DIRECTED_PLAN[row].reps; rep++) begin
                offer(DIRECTED_PLAN[row].op, DIRECTED_PLAN[row].value + rep,
                      DIRECTED_PLAN[row].typed, DIRECTED_PLAN[row].result);
            end
        end

        // Random commands in drifting phases with varying sender idle rates
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % 40 == 0) mix = t_mix'($urandom_range(0, 2));
            if (item % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       sender_idle_pct = 0;
                    1:       sender_idle_pct = 10;
                    default: sender_idle_pct = 30;
                endcase
            end
            if (item == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            offer(pick_command(mix), pick_value(), 1'b0, '0);
        end
        cmd_ch.valid <= 1'b0;

        // Drain outstanding responses, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d commands (%0d from the directed table) with send gaps and stalls",
                 commands_sent, commands_sent - RANDOM_ITEMS);
        $display("responses: %0d ok, %0d empty errors, %0d full errors, peak depth %0d",
                 ok_seen, empty_seen, full_seen, peak_count);
        if (error_count == 0) begin
            $display("double_ended_queue_test OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("double_ended_queue_test NOT OK");
        end
        $finish;
    end

endmodule

>>> double_ended_queue.f
src/deq_pkg.sv
src/deq_if.sv
src/deq_ram.sv
src/double_ended_queue.sv
test/double_ended_queue_test.sv
